>>> design/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

    // pending queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 72;

    // scheduling policy codes
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_LOOK = 2'd2;

    // item kind on the input tuser
    localparam logic FN_ARRIVE   = 1'b0;
    localparam logic FN_COMPLETE = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // one request as held in the queue and in service
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] tm;
        logic [15:0] cyl;
    } t_req;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // LOOK passes
    typedef enum logic [1:0] {
        P_SAME,
        P_AHEAD,
        P_NEAR
    } t_pass;

    // selection criterion used by the compare unit
    typedef enum logic [2:0] {
        M_TIME,
        M_SEEK_TIME,
        M_SAME_CYL,
        M_AHEAD,
        M_NEAR
    } t_mode;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic  clr;
        logic  ev;
        t_mode mode;
    } t_sel_ctl;

endpackage

`default_nettype wire

>>> design/disk_request_scheduler_unit.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler_unit
// Disk request scheduler: one request in service, a pending queue in RAM,
// FCFS / SSTF / LOOK selection on completion.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per request arrival (tuser low) or service
//   completion (tuser high). m_axis returns exactly one item per input item:
//   the request now in service, the drop flag and the queue occupancy.
//   i_cfg_wen / i_cfg_wdata write the policy; write only while idle.
//   An arrival, or a completion with an empty queue, presents its
//   result in the cycle after acceptance; no new item is taken until that
//   result is accepted. A completion with pending entries scans the queue
//   RAM (LOOK may need up to three passes), then closes the gap left by the
//   chosen entry, all through the single compare unit and the one RAM
//   read port.
//   s_axis_tready is high only while the block is idle; one item at a time.
//   When the receiver stalls the result holds on m_axis and no new item is
//   taken. Reset empties the queue, clears the in-service request and sets
//   the policy to first-come-first-served; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_scheduler_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_wen,
    input  wire  [1:0]                       i_cfg_wdata,   // policy
    // input items
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] req_id, [47:16] arrival_time, [63:48] cylinder,
    // [79:64] head_cylinder, [80] scan_up, [87:81] zero
    input  wire  [drs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire                              s_axis_tuser,  // [0] func
    // result items
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [15:0] out_req_id, [47:16] out_arrival_time, [63:48] out_cylinder,
    // [64] dropped, [69:65] pending_count, [71:70] zero
    output logic [drs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import drs_pkg::*;

    // state
    t_state      r_state, n_state;
    logic [1:0]  r_policy;
    t_req        r_svc, n_svc;
    t_cnt        r_total, n_total;
    logic        r_dropped, n_dropped;
    logic [15:0] r_head;
    logic        r_up;
    t_pass       r_pass, n_pass;
    t_cnt        r_idx, n_idx;
    logic        r_ev_vld, n_ev_vld;
    t_addr       r_ev_idx, n_ev_idx;
    t_addr       r_sh_addr, n_sh_addr;

    // RAM and compare unit connections
    logic        ram_we;
    t_addr       ram_waddr;
    t_req        ram_wdata;
    t_addr       ram_raddr;
    t_req        ram_rdata;
    t_sel_ctl    sel_ctl;
    logic        sel_found;
    t_addr       sel_idx;
    t_req        sel_ent;

    // input field split
    logic        in_acc;
    t_req        in_req;
    logic [15:0] in_head;
    logic        in_up;
    logic        issue;
    logic        pass_end;
    logic [8:0]  total_ext;
    logic [4:0]  count_sat;

    assign in_acc       = s_axis_tvalid && s_axis_tready;
    assign in_req.id    = s_axis_tdata[15:0];
    assign in_req.tm    = s_axis_tdata[47:16];
    assign in_req.cyl   = s_axis_tdata[63:48];
    assign in_head      = s_axis_tdata[79:64];
    assign in_up        = s_axis_tdata[80];
    assign issue        = (r_idx < r_total);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == FN_COMPLETE && r_total != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (!issue && !r_ev_vld) begin
                    if (!(r_policy == POL_LOOK && !sel_found && r_pass != P_NEAR)) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (!issue && !r_ev_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb begin
        n_svc       = r_svc;
        n_total     = r_total;
        n_dropped   = r_dropped;
        n_pass      = r_pass;
        n_idx       = r_idx;
        n_ev_vld    = 1'b0;
        n_ev_idx    = r_ev_idx;
        n_sh_addr   = r_sh_addr;
        ram_we      = 1'b0;
        ram_waddr   = r_sh_addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx[ADDR_W-1:0];
        sel_ctl.clr = 1'b0;
        sel_ctl.ev  = 1'b0;
        pass_end    = !issue && !r_ev_vld;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        // criterion for this pass
        unique case (r_policy)
            POL_SSTF: sel_ctl.mode = M_SEEK_TIME;
            POL_LOOK: begin
                unique case (r_pass)
                    P_SAME:  sel_ctl.mode = M_SAME_CYL;
                    P_AHEAD: sel_ctl.mode = M_AHEAD;
                    default: sel_ctl.mode = M_NEAR;
                endcase
            end
            default:  sel_ctl.mode = M_TIME;
        endcase

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    n_dropped = 1'b0;
                    n_pass    = P_SAME;
                    n_idx     = '0;
                    if (s_axis_tuser == FN_ARRIVE) begin
                        if (in_req.id != 16'd0) begin
                            if (r_svc.id == 16'd0) begin
                                n_svc = in_req;
                            end else if (r_total < t_cnt'(QUEUE_DEPTH)) begin
                                // append at the tail
                                ram_we    = 1'b1;
                                ram_waddr = r_total[ADDR_W-1:0];
                                ram_wdata = in_req;
                                n_total   = r_total + t_cnt'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                    end else if (r_total == '0) begin
                        n_svc = '0;
                    end else begin
                        sel_ctl.clr = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // read one entry per cycle, judge it the cycle after
                sel_ctl.ev = r_ev_vld;
                if (issue) begin
                    n_idx    = r_idx + t_cnt'(1);
                    n_ev_vld = 1'b1;
                    n_ev_idx = r_idx[ADDR_W-1:0];
                end
                if (pass_end) begin
                    if (r_policy == POL_LOOK && !sel_found && r_pass != P_NEAR) begin
                        // nothing eligible: next LOOK pass
                        sel_ctl.clr = 1'b1;
                        n_pass      = (r_pass == P_SAME) ? P_AHEAD : P_NEAR;
                        n_idx       = '0;
                    end else begin
                        n_svc = sel_ent;
                        n_idx = t_cnt'(sel_idx) + t_cnt'(1);
                    end
                end
            end
            S_SHIFT: begin
                // move later entries up one place
                ram_we = r_ev_vld;
                if (issue) begin
                    n_idx     = r_idx + t_cnt'(1);
                    n_ev_vld  = 1'b1;
                    n_sh_addr = t_addr'(r_idx - t_cnt'(1));
                end
                if (pass_end) begin
                    n_total = r_total - t_cnt'(1);
                end
            end
            S_DONE: begin
                m_axis_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_FCFS;
            r_svc    <= '0;
            r_total  <= '0;
            r_ev_vld <= 1'b0;
            r_pass   <= P_SAME;
        end else begin
            r_state  <= n_state;
            r_svc    <= n_svc;
            r_total  <= n_total;
            r_ev_vld <= n_ev_vld;
            r_pass   <= n_pass;
            if (i_cfg_wen) begin
                r_policy <= i_cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_dropped <= n_dropped;
        r_idx     <= n_idx;
        r_ev_idx  <= n_ev_idx;
        r_sh_addr <= n_sh_addr;
        if (in_acc) begin
            r_head <= in_head;
            r_up   <= in_up;
        end
    end

    // pending queue store
    drs_ram #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit
    drs_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_ent   (ram_rdata),
        .i_idx   (r_ev_idx),
        .i_head  (r_head),
        .i_up    (r_up),
        .o_found (sel_found),
        .o_idx   (sel_idx),
        .o_ent   (sel_ent)
    );

    // result item
    assign total_ext = 9'(r_total);
    assign count_sat = (total_ext > 9'd31) ? 5'd31 : total_ext[4:0];
    assign m_axis_tdata = {2'b00, count_sat, r_dropped, r_svc.cyl, r_svc.tm, r_svc.id};

endmodule

`default_nettype wire

>>> design/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                          i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/drs_sel.sv
// ----------------------------------------------------------------------------
// drs_sel
// Shared compare unit: forms a key for one queue entry per cycle and keeps
// the best eligible entry seen in the current pass.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_sel (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  drs_pkg::t_sel_ctl     i_ctl,
    input  drs_pkg::t_req         i_ent,
    input  drs_pkg::t_addr        i_idx,
    input  wire  [15:0]           i_head,
    input  wire                   i_up,
    output logic                  o_found,
    output drs_pkg::t_addr        o_idx,
    output drs_pkg::t_req         o_ent
);
    import drs_pkg::*;

    logic        r_found;
    logic [47:0] r_key;
    t_addr       r_idx;
    t_req        r_ent;

    logic [15:0] seek_len;
    logic        ahead;
    logic        elig;
    logic [47:0] key;
    logic        take;

    // distance to head and eligibility of this entry
    always_comb begin
        seek_len = (i_ent.cyl > i_head) ? (i_ent.cyl - i_head) : (i_head - i_ent.cyl);
        ahead    = i_up ? (i_ent.cyl > i_head) : (i_ent.cyl < i_head);
        elig     = 1'b1;
        key      = {16'd0, i_ent.tm};
        unique case (i_ctl.mode)
            M_TIME:      key = {16'd0, i_ent.tm};
            M_SEEK_TIME: key = {seek_len, i_ent.tm};
            M_SAME_CYL: begin
                key  = {16'd0, i_ent.tm};
                elig = (i_ent.cyl == i_head);
            end
            M_AHEAD: begin
                key  = {seek_len, 32'd0};
                elig = ahead;
            end
            M_NEAR:      key = {seek_len, 32'd0};
            default:     key = {16'd0, i_ent.tm};
        endcase
        // strict compare keeps the earlier queue position on a tie
        take = i_ctl.ev && elig && (!r_found || (key < r_key));
    end

    // best-so-far registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clr) begin
            r_key <= key;
            r_idx <= i_idx;
            r_ent <= i_ent;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_ent   = r_ent;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the disk request scheduler. A directed run fills the
// queue to overflow and drains part of it. Random phases then cover all four
// policy codes under varied sender and receiver idling. Each result item is
// checked against a scoreboard that tracks the in-service request and the
// ordered pending queue.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import drs_pkg::*;

    // policy code with no scheme of its own (falls back to FCFS)
    localparam logic [1:0] POL_SPARE  = 2'd3;
    localparam int         QUIET_MAX  = 4000;
    localparam int         PHASES     = 8;
    localparam int         PHASE_LEN  = 230;

    // expected content of one result item
    typedef struct {
        t_req        req;
        logic        dropped;
        logic [4:0]  count;
    } t_sched_result;

    // tracks scheduler state and checks result items in order
    class sched_scoreboard;
        t_req          waiting[$];
        t_req          serving;
        logic [1:0]    policy;
        t_sched_result due[$];
        int            errors;

        function new();
            serving = '0;
            policy  = POL_FCFS;
            errors  = 0;
        endfunction

        function int unsigned seek_distance(logic [15:0] a, logic [15:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        // index of the next request to serve under the current policy
        function int pick_next(logic [15:0] head, logic up);
            int          best;
            int unsigned bd;
            int unsigned d;
            bit          found;
            bit          ahead;
            best  = 0;
            bd    = 0;
            found = 1'b0;
            case (policy)
                POL_SSTF: begin
                    bd = seek_distance(waiting[0].cyl, head);
                    for (int i = 1; i < waiting.size(); i++) begin
                        d = seek_distance(waiting[i].cyl, head);
                        if (d < bd || (d == bd && waiting[i].tm < waiting[best].tm)) begin
                            bd   = d;
                            best = i;
                        end
                    end
                end
                POL_LOOK: begin
                    // same cylinder first, earliest arrival
                    for (int i = 0; i < waiting.size(); i++) begin
                        if (waiting[i].cyl == head &&
                            (!found || waiting[i].tm < waiting[best].tm)) begin
                            found = 1'b1;
                            best  = i;
                        end
                    end
                    // nearest strictly in the scan direction
                    if (!found) begin
                        for (int i = 0; i < waiting.size(); i++) begin
                            ahead = up ? (waiting[i].cyl > head) : (waiting[i].cyl < head);
                            d     = seek_distance(waiting[i].cyl, head);
                            if (ahead && (!found || d < bd)) begin
                                found = 1'b1;
                                bd    = d;
                                best  = i;
                            end
                        end
                    end
                    // nearest either way
                    if (!found) begin
                        for (int i = 0; i < waiting.size(); i++) begin
                            d = seek_distance(waiting[i].cyl, head);
                            if (!found || d < bd) begin
                                found = 1'b1;
                                bd    = d;
                                best  = i;
                            end
                        end
                    end
                end
                default: begin
                    for (int i = 1; i < waiting.size(); i++)
                        if (waiting[i].tm < waiting[best].tm)
                            best = i;
                end
            endcase
            return best;
        endfunction

        // accepted input item: advance state, queue the expected result
        function void record_item(logic f, t_req r, logic [15:0] head, logic up);
            t_sched_result e;
            int            k;
            e.dropped = 1'b0;
            if (f == FN_ARRIVE) begin
                if (r.id != 16'd0) begin
                    if (serving.id == 16'd0)
                        serving = r;
                    else if (waiting.size() < QUEUE_DEPTH)
                        waiting.push_back(r);
                    else
                        e.dropped = 1'b1;
                end
            end else if (waiting.size() == 0) begin
                serving = '0;
            end else begin
                k       = pick_next(head, up);
                serving = waiting[k];
                waiting.delete(k);
            end
            e.req   = serving;
            e.count = 5'(waiting.size());
            due.push_back(e);
        endfunction

        // accepted result item against the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_sched_result e;
            if (due.size() == 0) begin
                $error("result item with no expectation waiting: %0h", d);
                errors++;
                return;
            end
            e = due.pop_front();
            if (d[15:0] !== e.req.id) begin
                $error("out_req_id: expected %0h, actual %0h", e.req.id, d[15:0]);
                errors++;
            end
            if (d[47:16] !== e.req.tm) begin
                $error("out_arrival_time: expected %0h, actual %0h", e.req.tm, d[47:16]);
                errors++;
            end
            if (d[63:48] !== e.req.cyl) begin
                $error("out_cylinder: expected %0h, actual %0h", e.req.cyl, d[63:48]);
                errors++;
            end
            if (d[64] !== e.dropped) begin
                $error("dropped: expected %0h, actual %0h", e.dropped, d[64]);
                errors++;
            end
            if (d[69:65] !== e.count) begin
                $error("pending_count: expected %0d, actual %0d", e.count, d[69:65]);
                errors++;
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wen     = 1'b0;
    logic [1:0]            i_cfg_wdata   = 2'd0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     quiet_cycles  = 0;
    sched_scoreboard board         = new();

    disk_request_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver: check results, random stalls, count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // present one item, hold it until accepted, then note it
    task automatic send_item(input logic f, input t_req r, input logic [15:0] head,
                             input logic up);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {7'd0, up, head, r.cyl, r.tm, r.id};
        do @(posedge i_clk); while (!s_axis_tready);
        board.record_item(f, r, head, up);
    endtask

    // policy write once the block has returned every result
    task automatic write_policy(input logic [1:0] p);
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_wen    <= 1'b0;
        board.policy = p;
    endtask

    // random item; fill phases favour arrivals so the queue overflows
    task automatic send_random(input bit fill);
        logic        f;
        t_req        r;
        logic [15:0] head;
        logic        up;
        f    = ($urandom_range(0, 99) < (fill ? 75 : 30)) ? FN_ARRIVE : FN_COMPLETE;
        r.id = ($urandom_range(0, 31) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        // narrow ranges give timestamp and cylinder ties
        r.tm  = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 15));
        r.cyl = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
        head  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
        up    = 1'($urandom_range(0, 1));
        send_item(f, r, head, up);
    endtask

    // stimulus
    initial begin : stimulus
        t_req       r;
        logic [1:0] phase_policy [PHASES];
        phase_policy = '{POL_LOOK, POL_FCFS, POL_SSTF, POL_LOOK,
                         POL_SPARE, POL_SSTF, POL_LOOK, POL_FCFS};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_policy(POL_FCFS);

        // arrival without a request, then completion with nothing queued
        r = '{id: 16'd0, tm: 32'hFFFF_FFFF, cyl: 16'hFFFF};
        send_item(FN_ARRIVE, r, 16'd0, 1'b0);
        r = '{id: 16'hFFFF, tm: 32'd0, cyl: 16'd0};
        send_item(FN_COMPLETE, r, 16'hFFFF, 1'b1);
        // idle disk takes the arrival straight into service
        send_item(FN_ARRIVE, r, 16'd0, 1'b0);
        // fill the queue, with timestamp ties and the top cylinder
        for (int i = 1; i <= QUEUE_DEPTH; i++) begin
            r.id  = 16'(i);
            r.tm  = (i == QUEUE_DEPTH) ? 32'hFFFF_FFFF : 32'(i % 4);
            r.cyl = (i == QUEUE_DEPTH) ? 16'hFFFF : 16'((i % 5) * 100);
            send_item(FN_ARRIVE, r, 16'hFFFF, 1'b1);
        end
        // queue full: dropped
        r = '{id: 16'h8000, tm: 32'd7, cyl: 16'h1234};
        send_item(FN_ARRIVE, r, 16'd0, 1'b0);
        send_item(FN_COMPLETE, r, 16'd0, 1'b0);
        send_item(FN_COMPLETE, r, 16'hFFFF, 1'b1);
        send_item(FN_COMPLETE, r, 16'd200, 1'b1);
        send_item(FN_COMPLETE, r, 16'd300, 1'b0);

        // random phases across policies and idling patterns
        for (int p = 0; p < PHASES; p++) begin
            write_policy(phase_policy[p]);
            case (p / 2)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++)
                send_random(((n / 40) % 2) == 0);
        end

        // drain and finish
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/drs_pkg.sv
design/drs_ram.sv
design/drs_sel.sv
design/disk_request_scheduler_unit.sv
verif/testbench.sv
